// ===== src/nps_pkg.sv =====
// Package for the nearest point search block.
// Holds the sequencer state type, the control struct and fixed field widths.
package nps_pkg;

  localparam int unsigned TagBits = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_LOAD,
    ST_ROOT,
    ST_UPDATE
  } nps_state_e;

  typedef struct packed {
    logic sq_load;
    logic sq_step;
    logic rt_load;
    logic rt_step;
    logic commit;
  } nps_ctrl_t;

endpackage

// ===== src/nps_if.sv =====
// Valid/ready channel interfaces: candidate points in, nearest results out.
// Uses nps_pkg for the tag width.
interface nps_pt_if
  import nps_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] ref_x;
  logic [COORD_BITS-1:0] ref_y;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic [TagBits-1:0]    point_tag;
  logic                  first_item;
  logic                  last_item;

  modport source (output valid, ref_x, ref_y, point_x, point_y, point_tag, first_item,
                  last_item, input ready);
  modport sink (input valid, ref_x, ref_y, point_x, point_y, point_tag, first_item,
                last_item, output ready);
endinterface

interface nps_res_if
  import nps_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] nearest_x;
  logic [COORD_BITS-1:0] nearest_y;
  logic [TagBits-1:0]    nearest_tag;
  logic [COORD_BITS:0]   nearest_distance;

  modport source (output valid, nearest_x, nearest_y, nearest_tag, nearest_distance,
                  input ready);
  modport sink (input valid, nearest_x, nearest_y, nearest_tag, nearest_distance,
                output ready);
endinterface

// ===== src/nps_sqsum.sv =====
// Bit-serial sum of squares: |dx|^2 + |dy|^2, one multiplier bit per step.
// Depends on nps_pkg for the control struct.
module nps_sqsum
  import nps_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                      clk_i,
  input  nps_ctrl_t                 ctrl_i,
  input  logic [COORD_BITS-1:0]     adx_i,
  input  logic [COORD_BITS-1:0]     ady_i,
  output logic [2*COORD_BITS+1:0]   sum_o
);
  localparam int unsigned SumW = 2 * COORD_BITS + 2;

  logic [COORD_BITS-1:0] mx_q, mx_d, my_q, my_d;
  logic [SumW-1:0]       ax_q, ax_d, ay_q, ay_d, acc_q, acc_d;

  always_comb begin
    mx_d  = mx_q;
    my_d  = my_q;
    ax_d  = ax_q;
    ay_d  = ay_q;
    acc_d = acc_q;
    if (ctrl_i.sq_load) begin
      mx_d  = adx_i;
      my_d  = ady_i;
      ax_d  = SumW'(adx_i);
      ay_d  = SumW'(ady_i);
      acc_d = '0;
    end else if (ctrl_i.sq_step) begin
      acc_d = acc_q + (mx_q[0] ? ax_q : '0) + (my_q[0] ? ay_q : '0);
      mx_d  = mx_q >> 1;
      my_d  = my_q >> 1;
      ax_d  = ax_q << 1;
      ay_d  = ay_q << 1;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q  <= mx_d;
    my_q  <= my_d;
    ax_q  <= ax_d;
    ay_q  <= ay_d;
    acc_q <= acc_d;
  end

  assign sum_o = acc_q;

endmodule

// ===== src/nps_isqrt.sv =====
// Restoring integer square root, one result bit per step (two operand bits).
// Depends on nps_pkg for the control struct.
module nps_isqrt
  import nps_pkg::*;
#(
  parameter int unsigned ROOT_BITS = 13
) (
  input  logic                   clk_i,
  input  nps_ctrl_t              ctrl_i,
  input  logic [2*ROOT_BITS-1:0] op_i,
  output logic [ROOT_BITS-1:0]   root_o
);
  localparam int unsigned OpW = 2 * ROOT_BITS;

  logic [OpW-1:0]         op_q, op_d;
  logic [ROOT_BITS:0]     rem_q, rem_d;
  logic [ROOT_BITS-1:0]   root_q, root_d;
  logic [ROOT_BITS+2:0]   rem_sh, trial, diff;

  assign rem_sh = {rem_q, op_q[OpW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign diff   = rem_sh - trial;

  always_comb begin
    op_d   = op_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (ctrl_i.rt_load) begin
      op_d   = op_i;
      rem_d  = '0;
      root_d = '0;
    end else if (ctrl_i.rt_step) begin
      op_d = op_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = diff[ROOT_BITS:0];
        root_d = {root_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[ROOT_BITS:0];
        root_d = {root_q[ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;

endmodule

// ===== src/nps_best.sv =====
// Holds the current nearest candidate and the output register of the result channel.
// Depends on nps_pkg and the nps_res_if interface.
module nps_best
  import nps_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nps_ctrl_t             ctrl_i,
  input  logic                  first_i,
  input  logic                  last_i,
  input  logic [COORD_BITS:0]   dist_i,
  input  logic [COORD_BITS-1:0] px_i,
  input  logic [COORD_BITS-1:0] py_i,
  input  logic [TagBits-1:0]    tag_i,
  output logic                  out_busy_o,
  nps_res_if.source             res_o
);
  logic [COORD_BITS:0]   best_dist_q, best_dist_d;
  logic [COORD_BITS-1:0] best_x_q, best_x_d, best_y_q, best_y_d;
  logic [TagBits-1:0]    best_tag_q, best_tag_d;
  logic                  take;
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [TagBits-1:0]    out_tag_q;
  logic [COORD_BITS:0]   out_dist_q;

  assign take = ctrl_i.commit && (first_i || (dist_i < best_dist_q));

  always_comb begin
    best_dist_d = best_dist_q;
    best_x_d    = best_x_q;
    best_y_d    = best_y_q;
    best_tag_d  = best_tag_q;
    if (take) begin
      best_dist_d = dist_i;
      best_x_d    = px_i;
      best_y_d    = py_i;
      best_tag_d  = tag_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !res_o.ready;
    if (ctrl_i.commit && last_i) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= '0;
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_tag_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      best_dist_q <= best_dist_d;
      best_x_q    <= best_x_d;
      best_y_q    <= best_y_d;
      best_tag_q  <= best_tag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && last_i) begin
      out_x_q    <= best_x_d;
      out_y_q    <= best_y_d;
      out_tag_q  <= best_tag_d;
      out_dist_q <= best_dist_d;
    end
  end

  assign out_busy_o             = out_valid_q && !res_o.ready;
  assign res_o.valid            = out_valid_q;
  assign res_o.nearest_x        = out_x_q;
  assign res_o.nearest_y        = out_y_q;
  assign res_o.nearest_tag      = out_tag_q;
  assign res_o.nearest_distance = out_dist_q;

endmodule

// ===== src/nearest_point_search.sv =====
// Nearest point search: top level with the item register and the step sequencer.
// Depends on nps_pkg, nps_if, nps_sqsum, nps_isqrt and nps_best.
//
// Usage: candidate points arrive on pt_i, one per item, each with the
// reference position, a tag and first/last marks. An item marked first
// restarts the search; on an item marked last one result item leaves on
// res_o with the nearest candidate, its tag and floor(sqrt(dx^2 + dy^2)).
// Ties keep the earlier candidate.
// Steps: the squares are summed bit-serially in the square state, then the
// root is formed one bit a cycle in the root state. One item is worked on
// at a time: a new item is taken only once the sequencer is idle again.
// Reset clears the held winner to point (0,0), tag 0, distance 0, and
// empties the output register.
// Stalls: res_o has an output register, so the next items are taken while a
// result waits; only a further last item holds in its update cycle until
// the waiting result has been taken.
module nearest_point_search
  import nps_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nps_pt_if.sink    pt_i,
  nps_res_if.source res_o
);
  localparam int unsigned DistW = COORD_BITS + 1;
  localparam int unsigned CntW  = $clog2(DistW);
  localparam logic [CntW-1:0] SqLast = CntW'(COORD_BITS - 1);
  localparam logic [CntW-1:0] RtLast = CntW'(DistW - 1);

  nps_state_e state_q, state_d;
  nps_ctrl_t  ctrl;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic       out_busy;

  logic [COORD_BITS-1:0] px_q, py_q;
  logic [TagBits-1:0]    tag_q;
  logic                  first_q, last_q;

  logic [COORD_BITS:0]   dx, dy, adx_w, ady_w;
  logic [2*COORD_BITS+1:0] sum;
  logic [DistW-1:0]      cand_dist;

  assign dx    = {pt_i.point_x[COORD_BITS-1], pt_i.point_x}
               - {pt_i.ref_x[COORD_BITS-1], pt_i.ref_x};
  assign dy    = {pt_i.point_y[COORD_BITS-1], pt_i.point_y}
               - {pt_i.ref_y[COORD_BITS-1], pt_i.ref_y};
  assign adx_w = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
  assign ady_w = dy[COORD_BITS] ? (~dy + 1'b1) : dy;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (pt_i.valid) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SqLast) begin
          state_d = ST_LOAD;
          cnt_d   = '0;
        end
      end
      ST_LOAD: begin
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RtLast) begin
          state_d = ST_UPDATE;
          cnt_d   = '0;
        end
      end
      ST_UPDATE: begin
        if (!(last_q && out_busy)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctrl       = '0;
    pt_i.ready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pt_i.ready   = 1'b1;
        ctrl.sq_load = pt_i.valid;
      end
      ST_SQUARE: ctrl.sq_step = 1'b1;
      ST_LOAD:   ctrl.rt_load = 1'b1;
      ST_ROOT:   ctrl.rt_step = 1'b1;
      ST_UPDATE: ctrl.commit  = !(last_q && out_busy);
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.sq_load) begin
      px_q    <= pt_i.point_x;
      py_q    <= pt_i.point_y;
      tag_q   <= pt_i.point_tag;
      first_q <= pt_i.first_item;
      last_q  <= pt_i.last_item;
    end
  end

  nps_sqsum #(
    .COORD_BITS(COORD_BITS)
  ) u_sqsum (
    .clk_i (clk_i),
    .ctrl_i(ctrl),
    .adx_i (adx_w[COORD_BITS-1:0]),
    .ady_i (ady_w[COORD_BITS-1:0]),
    .sum_o (sum)
  );

  nps_isqrt #(
    .ROOT_BITS(DistW)
  ) u_isqrt (
    .clk_i (clk_i),
    .ctrl_i(ctrl),
    .op_i  (sum),
    .root_o(cand_dist)
  );

  nps_best #(
    .COORD_BITS(COORD_BITS)
  ) u_best (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .first_i   (first_q),
    .last_i    (last_q),
    .dist_i    (cand_dist),
    .px_i      (px_q),
    .py_i      (py_q),
    .tag_i     (tag_q),
    .out_busy_o(out_busy),
    .res_o     (res_o)
  );

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_i.valid && pt_i.ready) |=> (state_q == ST_SQUARE && cnt_q == '0))
    else $error("accepted item did not start squaring");

  a_square_to_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQUARE && cnt_q == SqLast) |=> (state_q == ST_LOAD))
    else $error("squaring did not hand over to the root unit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.commit && last_q) |-> !out_busy)
    else $error("result written over a waiting result");

  a_valid_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(state_q == ST_UPDATE))
    else $error("result raised outside the update cycle");

endmodule
